// ===== src/mmi_pkg.sv =====
package mmi_pkg;

    localparam int DATA_W = 32;
    localparam int DIFF_W = DATA_W + 1;
    localparam int CFG_IDX_W = 8;
    localparam int S_TDATA_W = 200;
    localparam int M_TDATA_W = 192;
    localparam int DSQ_W = 63;
    localparam int FRAC_W = 54;
    localparam int SQRT_STEPS = 32;

    typedef enum logic [2:0] {
        ACT_MIN_VEC   = 3'd0,
        ACT_MIN_IMAGE = 3'd1,
        ACT_FOLD_REAL = 3'd2,
        ACT_FOLD_FRAC = 3'd3,
        ACT_FRAC_REAL = 3'd4,
        ACT_RSVD5     = 3'd5,
        ACT_RSVD6     = 3'd6,
        ACT_RSVD7     = 3'd7
    } act_t;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_A_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_B_Y = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_C_X = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_C_Z = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_A_X  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_B_Y  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_C_X  = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INV_C_Z  = 8'd7;

    typedef struct packed {
        logic [30:0]        cell_a_x;
        logic [30:0]        cell_b_y;
        logic signed [31:0] cell_c_x;
        logic [30:0]        cell_c_z;
        logic signed [31:0] inv_a_x;
        logic signed [31:0] inv_b_y;
        logic signed [31:0] inv_c_x;
        logic signed [31:0] inv_c_z;
    } cfg_t;

    // classified item handed from the front end to the datapath
    typedef struct packed {
        act_t                     action;
        logic signed [DIFF_W-1:0] d_x;
        logic signed [DIFF_W-1:0] d_y;
        logic signed [DIFF_W-1:0] d_z;
        logic signed [DATA_W-1:0] q_x;
        logic signed [DATA_W-1:0] q_y;
        logic signed [DATA_W-1:0] q_z;
    } item_t;

    typedef struct packed {
        logic push;
        logic full;
    } push_ctl_t;

    typedef struct packed {
        logic pop;
        logic empty;
    } pop_ctl_t;

endpackage

// ===== src/mmi_front.sv =====
module mmi_front (
    input  logic                     s_tvalid,
    input  logic [mmi_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                     s_tready,
    output mmi_pkg::item_t           item,
    output logic                     push,
    input  logic                     full
);

    logic signed [mmi_pkg::DATA_W-1:0] p_x, p_y, p_z;
    logic signed [mmi_pkg::DATA_W-1:0] q_x, q_y, q_z;
    mmi_pkg::act_t act;
    logic diff_mode;

    assign act = mmi_pkg::act_t'(s_tdata[2:0]);
    assign p_x = $signed(s_tdata[34:3]);
    assign p_y = $signed(s_tdata[66:35]);
    assign p_z = $signed(s_tdata[98:67]);
    assign q_x = $signed(s_tdata[130:99]);
    assign q_y = $signed(s_tdata[162:131]);
    assign q_z = $signed(s_tdata[194:163]);

    assign diff_mode = (act == mmi_pkg::ACT_MIN_VEC) || (act == mmi_pkg::ACT_MIN_IMAGE);

    always_comb begin
        item.action = act;
        item.q_x = q_x;
        item.q_y = q_y;
        item.q_z = q_z;
        if (diff_mode) begin
            item.d_x = 33'(q_x) - 33'(p_x);
            item.d_y = 33'(q_y) - 33'(p_y);
            item.d_z = 33'(q_z) - 33'(p_z);
        end else begin
            item.d_x = 33'(p_x);
            item.d_y = 33'(p_y);
            item.d_z = 33'(p_z);
        end
    end

    assign s_tready = !full;
    assign push = s_tvalid && !full;

endmodule

// ===== src/mmi_queue.sv =====
module mmi_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  mmi_pkg::push_ctl_t  wr_ctl_unused_guard,
    input  mmi_pkg::item_t      wr_item,
    input  logic                push,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output mmi_pkg::item_t      rd_item
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    mmi_pkg::item_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic do_push, do_pop;

    assign full = (count_reg == (PTR_W+1)'(DEPTH)) || wr_ctl_unused_guard.full;
    assign empty = (count_reg == '0);
    assign do_push = push && !full && wr_ctl_unused_guard.push;
    assign do_pop = pop && !empty;
    assign rd_item = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
        end
    end

endmodule

// ===== src/mmi_back.sv =====
module mmi_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  mmi_pkg::cfg_t       cfg,
    input  mmi_pkg::item_t      in_item,
    input  logic                in_avail,
    output logic                in_take,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [mmi_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int FW = mmi_pkg::FRAC_W;
    localparam int NS = mmi_pkg::SQRT_STEPS;
    localparam logic signed [FW-1:0] HALF = FW'(64'sh8000_0000);
    localparam logic signed [FW-1:0] ONE  = FW'(64'sh1_0000_0000);
    localparam logic signed [57:0] S32_MAX = 58'sh7FFF_FFFF;
    localparam logic signed [57:0] S32_MIN = -58'sh8000_0000;
    localparam logic [64:0] DSQ_MAX = 65'h7FFF_FFFF_FFFF_FFFF;

    logic en;
    assign en = !m_tvalid || m_tready;
    assign in_take = en && in_avail;

    // stage 1: inverse products
    logic v1_reg;
    mmi_pkg::act_t a1_reg;
    logic signed [31:0] q1_reg [3];
    logic signed [32:0] dx1_reg;
    logic signed [64:0] pa1_reg, pc1_reg, pb1_reg, pz1_reg;

    // stage 2: fractions before correction
    logic v2_reg;
    mmi_pkg::act_t a2_reg;
    logic signed [31:0] q2_reg [3];
    logic signed [FW-1:0] fr2_reg [3];
    logic signed [67:0] sum0_next;
    logic signed [FW-1:0] fr_next [3];

    // stage 3: corrected or folded fractions
    logic v3_reg;
    mmi_pkg::act_t a3_reg;
    logic signed [31:0] q3_reg [3];
    logic signed [FW-1:0] f3_reg [3];
    logic signed [FW-1:0] f_next [3];

    // stage 4: cell products
    logic v4_reg;
    mmi_pkg::act_t a4_reg;
    logic signed [31:0] q4_reg [3];
    logic [15:0] fo4_reg [3];
    logic signed [64:0] ml4_reg [4];
    logic signed [53:0] mh4_reg [4];

    // stage 5: low and high partial sums
    logic v5_reg;
    mmi_pkg::act_t a5_reg;
    logic signed [31:0] q5_reg [3];
    logic [15:0] fo5_reg [3];
    logic signed [65:0] lo5_reg [3];
    logic signed [54:0] hi5_reg [3];

    // stage 6: back-mapped vector
    logic v6_reg;
    mmi_pkg::act_t a6_reg;
    logic signed [31:0] q6_reg [3];
    logic [15:0] fo6_reg [3];
    logic signed [56:0] r6_reg [3];

    // stage 7: emitted vector
    logic v7_reg;
    logic min7_reg;
    logic signed [31:0] o7_reg [3];
    logic signed [31:0] o_next [3];

    // stage 8: squares
    logic v8_reg;
    logic min8_reg;
    logic signed [31:0] o8_reg [3];
    logic [62:0] sq8_reg [3];

    // stage 9: squared length
    logic v9_reg;
    logic signed [31:0] o9_reg [3];
    logic [62:0] dsq9_reg;
    logic [64:0] sqsum_next;

    logic signed [32:0] cell_a, cell_b, cell_cz;

    assign cell_a  = $signed({2'b0, cfg.cell_a_x});
    assign cell_b  = $signed({2'b0, cfg.cell_b_y});
    assign cell_cz = $signed({2'b0, cfg.cell_c_z});

    always_comb begin
        sum0_next = 68'(pa1_reg) + 68'(pc1_reg);
        fr_next[1] = FW'(pb1_reg >>> 14);
        fr_next[2] = FW'(pz1_reg >>> 14);
        if (a1_reg == mmi_pkg::ACT_FRAC_REAL) begin
            fr_next[0] = {{5{dx1_reg[32]}}, dx1_reg, 16'b0};
        end else begin
            fr_next[0] = sum0_next[67:14];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            priority if (a2_reg == mmi_pkg::ACT_MIN_VEC || a2_reg == mmi_pkg::ACT_MIN_IMAGE) begin
                if (fr2_reg[k] < -HALF) begin
                    f_next[k] = fr2_reg[k] + ONE;
                end else if (fr2_reg[k] > HALF) begin
                    f_next[k] = fr2_reg[k] - ONE;
                end else begin
                    f_next[k] = fr2_reg[k];
                end
            end else if (a2_reg == mmi_pkg::ACT_FOLD_REAL || a2_reg == mmi_pkg::ACT_FOLD_FRAC) begin
                f_next[k] = {{(FW-32){1'b0}}, fr2_reg[k][31:0]};
            end else begin
                f_next[k] = fr2_reg[k];
            end
        end
    end

    always_comb begin
        logic signed [57:0] s;
        for (int k = 0; k < 3; k++) begin
            s = 58'(r6_reg[k]) + ((a6_reg == mmi_pkg::ACT_MIN_IMAGE) ? 58'(q6_reg[k]) : 58'sd0);
            unique case (a6_reg)
                mmi_pkg::ACT_MIN_VEC, mmi_pkg::ACT_MIN_IMAGE,
                mmi_pkg::ACT_FOLD_REAL, mmi_pkg::ACT_FRAC_REAL: begin
                    if (s > S32_MAX) begin
                        o_next[k] = 32'sh7FFF_FFFF;
                    end else if (s < S32_MIN) begin
                        o_next[k] = -32'sh8000_0000;
                    end else begin
                        o_next[k] = s[31:0];
                    end
                end
                mmi_pkg::ACT_FOLD_FRAC: o_next[k] = {16'b0, fo6_reg[k]};
                default: o_next[k] = '0;
            endcase
        end
    end

    assign sqsum_next = 65'(sq8_reg[0]) + 65'(sq8_reg[1]) + 65'(sq8_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
            v5_reg <= 1'b0; v6_reg <= 1'b0; v7_reg <= 1'b0; v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_avail;
            v2_reg <= v1_reg; v3_reg <= v2_reg; v4_reg <= v3_reg;
            v5_reg <= v4_reg; v6_reg <= v5_reg; v7_reg <= v6_reg;
            v8_reg <= v7_reg; v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg <= in_item.action;
            q1_reg[0] <= in_item.q_x;
            q1_reg[1] <= in_item.q_y;
            q1_reg[2] <= in_item.q_z;
            dx1_reg <= in_item.d_x;
            pa1_reg <= cfg.inv_a_x * in_item.d_x;
            pc1_reg <= cfg.inv_c_x * in_item.d_z;
            // frac-to-real reuses these slots for the shifted input
            if (in_item.action == mmi_pkg::ACT_FRAC_REAL) begin
                pb1_reg <= 65'(in_item.d_y) <<< 30;
                pz1_reg <= 65'(in_item.d_z) <<< 30;
            end else begin
                pb1_reg <= cfg.inv_b_y * in_item.d_y;
                pz1_reg <= cfg.inv_c_z * in_item.d_z;
            end

            a2_reg <= a1_reg;
            q2_reg <= q1_reg;
            fr2_reg <= fr_next;

            a3_reg <= a2_reg;
            q3_reg <= q2_reg;
            f3_reg <= f_next;

            a4_reg <= a3_reg;
            q4_reg <= q3_reg;
            for (int k = 0; k < 3; k++) begin
                fo4_reg[k] <= f3_reg[k][31:16];
            end
            ml4_reg[0] <= cell_a * $signed({1'b0, f3_reg[0][31:0]});
            mh4_reg[0] <= cell_a * $signed(f3_reg[0][FW-1:32]);
            ml4_reg[1] <= cfg.cell_c_x * $signed({1'b0, f3_reg[2][31:0]});
            mh4_reg[1] <= cfg.cell_c_x * $signed(f3_reg[2][FW-1:32]);
            ml4_reg[2] <= cell_b * $signed({1'b0, f3_reg[1][31:0]});
            mh4_reg[2] <= cell_b * $signed(f3_reg[1][FW-1:32]);
            ml4_reg[3] <= cell_cz * $signed({1'b0, f3_reg[2][31:0]});
            mh4_reg[3] <= cell_cz * $signed(f3_reg[2][FW-1:32]);

            a5_reg <= a4_reg;
            q5_reg <= q4_reg;
            fo5_reg <= fo4_reg;
            lo5_reg[0] <= 66'(ml4_reg[0]) + 66'(ml4_reg[1]);
            hi5_reg[0] <= 55'(mh4_reg[0]) + 55'(mh4_reg[1]);
            lo5_reg[1] <= 66'(ml4_reg[2]);
            hi5_reg[1] <= 55'(mh4_reg[2]);
            lo5_reg[2] <= 66'(ml4_reg[3]);
            hi5_reg[2] <= 55'(mh4_reg[3]);

            a6_reg <= a5_reg;
            q6_reg <= q5_reg;
            fo6_reg <= fo5_reg;
            for (int k = 0; k < 3; k++) begin
                r6_reg[k] <= 57'(hi5_reg[k]) + 57'($signed(lo5_reg[k][65:32]));
            end

            min7_reg <= (a6_reg == mmi_pkg::ACT_MIN_VEC) || (a6_reg == mmi_pkg::ACT_MIN_IMAGE);
            o7_reg <= o_next;

            min8_reg <= min7_reg;
            o8_reg <= o7_reg;
            for (int k = 0; k < 3; k++) begin
                sq8_reg[k] <= 63'(64'(o7_reg[k]) * 64'(o7_reg[k]));
            end

            o9_reg <= o8_reg;
            if (!min8_reg) begin
                dsq9_reg <= '0;
            end else if (sqsum_next > DSQ_MAX) begin
                dsq9_reg <= DSQ_MAX[62:0];
            end else begin
                dsq9_reg <= sqsum_next[62:0];
            end
        end
    end

    // square root, one result bit per stage
    logic             sv_reg  [NS];
    logic signed [31:0] so_reg [NS][3];
    logic [62:0]      sd_reg  [NS];
    logic [63:0]      sbits_reg [NS];
    logic [35:0]      srem_reg [NS];
    logic [31:0]      sres_reg [NS];

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_sqrt
            logic             v_in;
            logic signed [31:0] o_in [3];
            logic [62:0]      d_in;
            logic [63:0]      b_in;
            logic [35:0]      rem_in, rem_sh, trial;
            logic [31:0]      res_in;
            logic             ge;

            if (g == 0) begin : g_first
                assign v_in = v9_reg;
                assign o_in = o9_reg;
                assign d_in = dsq9_reg;
                assign b_in = {1'b0, dsq9_reg};
                assign rem_in = '0;
                assign res_in = '0;
            end else begin : g_next
                assign v_in = sv_reg[g-1];
                assign o_in = so_reg[g-1];
                assign d_in = sd_reg[g-1];
                assign b_in = sbits_reg[g-1];
                assign rem_in = srem_reg[g-1];
                assign res_in = sres_reg[g-1];
            end

            assign rem_sh = {rem_in[33:0], b_in[63:62]};
            assign trial = {2'b0, res_in, 2'b01};
            assign ge = (rem_sh >= trial);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    sv_reg[g] <= 1'b0;
                end else if (en) begin
                    sv_reg[g] <= v_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    so_reg[g] <= o_in;
                    sd_reg[g] <= d_in;
                    sbits_reg[g] <= {b_in[61:0], 2'b00};
                    srem_reg[g] <= ge ? (rem_sh - trial) : rem_sh;
                    sres_reg[g] <= {res_in[30:0], ge};
                end
            end
        end
    endgenerate

    assign m_tvalid = sv_reg[NS-1];
    assign m_tdata = {1'b0, sres_reg[NS-1], sd_reg[NS-1],
                      so_reg[NS-1][2], so_reg[NS-1][1], so_reg[NS-1][0]};

endmodule

// ===== src/monoclinic_minimum_image.sv =====
// Pipeline: 9 arithmetic stages and 32 square root stages lead to the m_ side.
// Throughput: one item per cycle while the output is not stalled; a 4-entry
// queue behind the input keeps taking items while the result register is
// stalled, and the whole datapath holds.
// Reset (aresetn low, synchronous): queue and pipeline emptied, cell and
// inverse registers return to the unit cube.
module monoclinic_minimum_image (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // action[2:0], first_x, first_y, first_z, second_x, second_y, second_z
    input  logic [mmi_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_x[31:0], out_y, out_z, dist_sq[62:0], dist_res[31:0]
    output logic [mmi_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mmi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_data
);

    mmi_pkg::cfg_t cfg_reg;
    mmi_pkg::item_t front_item, queue_item;
    mmi_pkg::push_ctl_t push_ctl;
    logic push, full, pop, empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cell_a_x <= 31'd65536;
            cfg_reg.cell_b_y <= 31'd65536;
            cfg_reg.cell_c_x <= '0;
            cfg_reg.cell_c_z <= 31'd65536;
            cfg_reg.inv_a_x <= 32'sh4000_0000;
            cfg_reg.inv_b_y <= 32'sh4000_0000;
            cfg_reg.inv_c_x <= '0;
            cfg_reg.inv_c_z <= 32'sh4000_0000;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mmi_pkg::REG_CELL_A_X: cfg_reg.cell_a_x <= cfg_data[30:0];
                mmi_pkg::REG_CELL_B_Y: cfg_reg.cell_b_y <= cfg_data[30:0];
                mmi_pkg::REG_CELL_C_X: cfg_reg.cell_c_x <= cfg_data;
                mmi_pkg::REG_CELL_C_Z: cfg_reg.cell_c_z <= cfg_data[30:0];
                mmi_pkg::REG_INV_A_X:  cfg_reg.inv_a_x <= cfg_data;
                mmi_pkg::REG_INV_B_Y:  cfg_reg.inv_b_y <= cfg_data;
                mmi_pkg::REG_INV_C_X:  cfg_reg.inv_c_x <= cfg_data;
                mmi_pkg::REG_INV_C_Z:  cfg_reg.inv_c_z <= cfg_data;
                default: ;
            endcase
        end
    end

    mmi_front u_front (
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tready (s_tready),
        .item     (front_item),
        .push     (push),
        .full     (full)
    );

    assign push_ctl.push = 1'b1;
    assign push_ctl.full = 1'b0;

    mmi_queue u_queue (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .wr_ctl_unused_guard (push_ctl),
        .wr_item             (front_item),
        .push                (push),
        .full                (full),
        .pop                 (pop),
        .empty               (empty),
        .rd_item             (queue_item)
    );

    mmi_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_item  (queue_item),
        .in_avail (!empty),
        .in_take  (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== src/mmi_checker.sv =====
module mmi_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mmi_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [63:0] root_sq;
    assign root_sq = 64'(m_tdata[190:159]) * 64'(m_tdata[190:159]);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_root: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> root_sq <= 64'(m_tdata[158:96]))
        else $error("distance root too large");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[158:96] == '0 |-> m_tdata[190:159] == '0)
        else $error("nonzero root of zero distance");

endmodule

bind monoclinic_minimum_image mmi_checker u_mmi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/monoclinic_minimum_image_checker.sv =====
`timescale 1ns / 100ps

module monoclinic_minimum_image_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mmi_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mmi_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [mmi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data,
    output int                              errors,
    output int                              pending
);

    typedef logic signed [127:0] wide_t;

    // cell and inverse registers as the block should hold them
    wide_t cell_ax, cell_by, cell_cx, cell_cz;
    wide_t inv_ax, inv_by, inv_cx, inv_cz;

    logic [mmi_pkg::M_TDATA_W-1:0] image_q[$];

    initial errors = 0;
    assign pending = image_q.size();

    function automatic wide_t sat_q16(wide_t v);
        if (v > 128'sd2147483647) return 128'sd2147483647;
        if (v < -128'sd2147483648) return -128'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [mmi_pkg::M_TDATA_W-1:0] predict_image(
            logic [mmi_pkg::S_TDATA_W-1:0] item);
        mmi_pkg::act_t act;
        wide_t p[3], q[3], d[3], f[3], r[3], o[3];
        logic [127:0] dsq;
        logic [63:0] root;
        logic min_mode;
        act = mmi_pkg::act_t'(item[2:0]);
        min_mode = (act == mmi_pkg::ACT_MIN_VEC) || (act == mmi_pkg::ACT_MIN_IMAGE);
        for (int k = 0; k < 3; k++) begin
            p[k] = $signed(item[3 + 32*k +: 32]);
            q[k] = $signed(item[99 + 32*k +: 32]);
            o[k] = 0;
        end
        dsq = 0;
        root = 0;
        if (act inside {mmi_pkg::ACT_MIN_VEC, mmi_pkg::ACT_MIN_IMAGE, mmi_pkg::ACT_FOLD_REAL,
                        mmi_pkg::ACT_FOLD_FRAC, mmi_pkg::ACT_FRAC_REAL}) begin
            for (int k = 0; k < 3; k++)
                d[k] = min_mode ? q[k] - p[k] : p[k];
            if (act == mmi_pkg::ACT_FRAC_REAL) begin
                for (int k = 0; k < 3; k++) f[k] = d[k] * 65536;
            end else begin
                f[0] = (inv_ax * d[0] + inv_cx * d[2]) >>> 14;
                f[1] = (inv_by * d[1]) >>> 14;
                f[2] = (inv_cz * d[2]) >>> 14;
                for (int k = 0; k < 3; k++) begin
                    if (min_mode) begin
                        // single wrap; exactly half a cell stays put
                        if (f[k] < -(128'sd1 <<< 31)) f[k] = f[k] + (128'sd1 <<< 32);
                        else if (f[k] > (128'sd1 <<< 31)) f[k] = f[k] - (128'sd1 <<< 32);
                    end else begin
                        f[k] = f[k] & 128'hFFFF_FFFF;
                    end
                end
            end
            if (act == mmi_pkg::ACT_FOLD_FRAC) begin
                for (int k = 0; k < 3; k++) o[k] = f[k] >>> 16;
            end else begin
                r[0] = (cell_ax * f[0] + cell_cx * f[2]) >>> 32;
                r[1] = (cell_by * f[1]) >>> 32;
                r[2] = (cell_cz * f[2]) >>> 32;
                for (int k = 0; k < 3; k++)
                    o[k] = sat_q16(act == mmi_pkg::ACT_MIN_IMAGE ? r[k] + q[k] : r[k]);
            end
            if (min_mode) begin
                for (int k = 0; k < 3; k++) dsq = dsq + o[k] * o[k];
                if (dsq > 128'h7FFF_FFFF_FFFF_FFFF) dsq = 128'h7FFF_FFFF_FFFF_FFFF;
                root = floor_root(dsq[63:0]);
            end
        end
        return {1'b0, root[31:0], dsq[62:0], o[2][31:0], o[1][31:0], o[0][31:0]};
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            image_q.delete();
            cell_ax <= 65536; cell_by <= 65536; cell_cx <= 0; cell_cz <= 65536;
            inv_ax <= 1 <<< 30; inv_by <= 1 <<< 30; inv_cx <= 0; inv_cz <= 1 <<< 30;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    mmi_pkg::REG_CELL_A_X: cell_ax <= {97'b0, cfg_data[30:0]};
                    mmi_pkg::REG_CELL_B_Y: cell_by <= {97'b0, cfg_data[30:0]};
                    mmi_pkg::REG_CELL_C_X: cell_cx <= $signed(cfg_data);
                    mmi_pkg::REG_CELL_C_Z: cell_cz <= {97'b0, cfg_data[30:0]};
                    mmi_pkg::REG_INV_A_X:  inv_ax  <= $signed(cfg_data);
                    mmi_pkg::REG_INV_B_Y:  inv_by  <= $signed(cfg_data);
                    mmi_pkg::REG_INV_C_X:  inv_cx  <= $signed(cfg_data);
                    mmi_pkg::REG_INV_C_Z:  inv_cz  <= $signed(cfg_data);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                image_q.push_back(predict_image(s_tdata));
            if (m_tvalid && m_tready) begin
                if (image_q.size() == 0) begin
                    report_mismatch("unexpected item", m_tdata[63:0], 64'd0);
                end else begin
                    logic [mmi_pkg::M_TDATA_W-1:0] want;
                    want = image_q.pop_front();
                    if (m_tdata[31:0] !== want[31:0])
                        report_mismatch("out_x", m_tdata[31:0], want[31:0]);
                    if (m_tdata[63:32] !== want[63:32])
                        report_mismatch("out_y", m_tdata[63:32], want[63:32]);
                    if (m_tdata[95:64] !== want[95:64])
                        report_mismatch("out_z", m_tdata[95:64], want[95:64]);
                    if (m_tdata[158:96] !== want[158:96])
                        report_mismatch("dist_sq", m_tdata[158:96], want[158:96]);
                    if (m_tdata[190:159] !== want[190:159])
                        report_mismatch("dist_res", m_tdata[190:159], want[190:159]);
                end
            end
        end
    end

endmodule

// ===== tb/sv/monoclinic_minimum_image_tb.sv =====
`timescale 1ns / 100ps

module monoclinic_minimum_image_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 60;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [mmi_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [mmi_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [mmi_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [31:0]                    cfg_data = '0;
    int                             errors;
    int                             pending;
    int                             cycles = 0;
    bit                             long_hold = 0;
    bit                             no_idle = 0;

    always #5 aclk = ~aclk;

    monoclinic_minimum_image u_top (.*);

    monoclinic_minimum_image_checker u_check (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 12);
    endfunction

    // result side: random stalls, one long hold-off on request
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            n = draw_gap();
            if (long_hold) begin
                long_hold = 0;
                n = 300;
            end
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_item(mmi_pkg::act_t act, logic [31:0] px, py, pz, qx, qy, qz);
        int n;
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, qz, qy, qx, pz, py, px, act};
        do @(posedge aclk); while (!s_tready);
        n = draw_gap();
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // block must be idle: wait out results and the pipeline behind them
    task automatic write_cell(logic [31:0] vals[8]);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= mmi_pkg::CFG_IDX_W'(i);
            cfg_data <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] clamp32(logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -128'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // a plausible monoclinic cell with its matching inverse
    task automatic write_random_cell();
        logic signed [127:0] a, b, cx, cz;
        logic [31:0] vals[8];
        a = $urandom_range(32'h8001, 32'h0010_0000);
        b = $urandom_range(32'h8001, 32'h0010_0000);
        cz = $urandom_range(32'h8001, 32'h0010_0000);
        cx = $signed(32'($urandom_range(0, 2 * a[31:0]))) - a;
        vals[0] = a[31:0];
        vals[1] = b[31:0];
        vals[2] = cx[31:0];
        vals[3] = cz[31:0];
        vals[4] = clamp32((128'sd1 <<< 46) / a);
        vals[5] = clamp32((128'sd1 <<< 46) / b);
        vals[6] = clamp32(-(cx <<< 46) / (a * cz));
        vals[7] = clamp32((128'sd1 <<< 46) / cz);
        write_cell(vals);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
        endcase
    endfunction

    function automatic mmi_pkg::act_t rand_action();
        if ($urandom_range(0, 9) == 0) return mmi_pkg::act_t'($urandom_range(5, 7));
        return mmi_pkg::act_t'($urandom_range(0, 4));
    endfunction

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_item(rand_action(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord());
    endtask

    initial begin
        logic [31:0] vals[8];
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unit cell: half-cell ties, just past them, extremes, every code
        send_item(mmi_pkg::ACT_MIN_VEC, 0, 0, 0, 32'h8000, 32'hFFFF_8000, 32'h8000);
        send_item(mmi_pkg::ACT_MIN_VEC, 0, 0, 0, 32'h8001, 32'hFFFF_7FFF, 32'h7FFF);
        send_item(mmi_pkg::ACT_MIN_IMAGE, 32'h8000, 0, 0, 0, 32'h8000, 32'hFFFF_0000);
        send_item(mmi_pkg::ACT_MIN_VEC, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(mmi_pkg::ACT_MIN_IMAGE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(mmi_pkg::ACT_FOLD_REAL, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000,
                  0, 0, 0);
        send_item(mmi_pkg::ACT_FOLD_REAL, 32'h7FFF_FFFF, 32'h0002_8000, 32'hFFFE_0000,
                  0, 0, 0);
        send_item(mmi_pkg::ACT_FOLD_FRAC, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000,
                  0, 0, 0);
        send_item(mmi_pkg::ACT_FOLD_FRAC, 32'h7FFF_FFFF, 32'h0000_8000, 32'hFFFF_4000,
                  0, 0, 0);
        send_item(mmi_pkg::ACT_FRAC_REAL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000,
                  0, 0, 0);
        send_item(mmi_pkg::ACT_FRAC_REAL, 32'hFFFF_FFFF, 0, 32'h0001_0000, 0, 0, 0);
        send_item(mmi_pkg::ACT_RSVD5, 32'h1234_5678, 32'hFFFF_FFFF, 1, 2, 3, 4);
        send_item(mmi_pkg::ACT_RSVD6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(mmi_pkg::ACT_RSVD7, 0, 0, 0, 0, 0, 0);
        send_random(120);

        // receiver holds off while items keep coming
        write_random_cell();
        long_hold = 1;
        no_idle = 1;
        send_random(80);
        no_idle = 0;
        send_random(110);

        // largest register values
        vals = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        write_cell(vals);
        send_random(120);

        // smallest register values
        vals = '{32'h1, 32'h1, 32'h7FFF_FFFF, 32'h1,
                 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        write_cell(vals);
        send_random(120);

        write_random_cell();
        no_idle = 1;
        send_random(120);
        no_idle = 0;

        write_random_cell();
        send_random(210);
        s_tvalid <= 1'b0;
        @(posedge aclk);

        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mmi_pkg.sv
src/mmi_front.sv
src/mmi_queue.sv
src/mmi_back.sv
src/monoclinic_minimum_image.sv
src/mmi_checker.sv
tb/sv/monoclinic_minimum_image_checker.sv
tb/sv/monoclinic_minimum_image_tb.sv
